// File: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and the control bundle of the sliding window maximum.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_WIDTH      = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd4;

    typedef struct packed {
        logic step;
        logic kill;
        logic shift;
        logic append;
        logic clear;
    } t_cell_ctl;

endpackage

// File: src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One deque slot: value, age and valid, with a one-place shift toward front.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
    localparam int AW = $clog2(WINDOW_MAX + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swm_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_sample,
    input  logic                  i_next_valid,
    input  logic [DATA_WIDTH-1:0] i_next_value,
    input  logic [AW-1:0]         i_next_age,
    input  logic                  i_prev_svalid,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic [AW-1:0]         o_age,
    output logic                  o_svalid
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_value;
    logic [AW-1:0]         r_age;

    logic                  s_valid;
    logic [DATA_WIDTH-1:0] s_value;
    logic [AW-1:0]         s_age;
    logic                  here;

    always_comb begin
        o_valid = r_valid && !(i_ctl.kill && ($signed(r_value) < $signed(i_sample)));
        o_value = r_value;
        o_age   = r_age;
        if (r_valid && i_ctl.kill && (r_age != AW'(WINDOW_MAX))) begin
            o_age = r_age + 1'b1;
        end
    end

    assign s_valid  = i_ctl.shift ? i_next_valid : o_valid;
    assign s_value  = i_ctl.shift ? i_next_value : o_value;
    assign s_age    = i_ctl.shift ? i_next_age   : o_age;
    assign o_svalid = s_valid;
    assign here     = i_ctl.append && !s_valid && i_prev_svalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_valid <= (here || s_valid) && !i_ctl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_value <= here ? i_sample : s_value;
            r_age   <= here ? '0 : s_age;
        end
    end

endmodule

// File: src/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum of the last window_size signed samples of a stream.
// ----------------------------------------------------------------------------
// Normally the chain of WINDOW_MAX cells drops smaller rear candidates,
// retires one expired front candidate and appends the sample in one step.
// After window_size is lowered mid-array, every further expired front
// candidate costs one more drain step, since the chain moves its contents
// forward by one place per step; input ready is low meanwhile. Input ready
// is also low while a result beat waits for the receiver, since a sample beat
// is taken only when the output register is free. The first result of an
// array appears once window_size samples have been seen. A tlast beat returns
// its result with tlast set if one is due, and then empties the deque.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
    localparam int TW = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [TW-1:0]                 i_s_axis_tdata,  // sample
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [TW-1:0]                 o_m_axis_tdata,  // window_max
    output logic                          o_m_axis_tlast
);

    localparam int AW = $clog2(WINDOW_MAX + 1);
    localparam int CW = swm_pkg::CFG_WIDTH;
    localparam int WW = (AW > CW) ? AW : CW;

    logic [CW-1:0]         r_win;
    logic                  r_drain;
    logic [DATA_WIDTH-1:0] r_pend_v;
    logic                  r_pend_last;
    logic [AW-1:0]         r_seen;
    logic                  r_o_valid;
    logic [DATA_WIDTH-1:0] r_o_data;
    logic                  r_o_last;

    logic [WW-1:0]         win_wide;
    logic [AW-1:0]         win;
    logic                  out_free;
    logic                  accept;
    logic [DATA_WIDTH-1:0] cur_v;
    logic                  cur_last;
    logic                  drop1;
    logic                  full;
    logic                  more;
    logic                  append;
    logic [AW-1:0]         n_seen;
    logic                  emit;
    logic [DATA_WIDTH-1:0] front;
    swm_pkg::t_cell_ctl    ctl;

    logic                  w_valid  [WINDOW_MAX];
    logic [DATA_WIDTH-1:0] w_value  [WINDOW_MAX];
    logic [AW-1:0]         w_age    [WINDOW_MAX];
    logic                  w_svalid [WINDOW_MAX];

    always_comb begin
        win_wide = WW'(r_win);
        if (win_wide == '0) begin
            win_wide = WW'(1);
        end else if (win_wide > WW'(WINDOW_MAX)) begin
            win_wide = WW'(WINDOW_MAX);
        end
        win = win_wide[AW-1:0];
    end

    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_drain && out_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign cur_v           = r_drain ? r_pend_v : i_s_axis_tdata[DATA_WIDTH-1:0];
    assign cur_last        = r_drain ? r_pend_last : i_s_axis_tlast;

    assign drop1  = w_valid[0] && (w_age[0] >= win);
    assign full   = w_valid[WINDOW_MAX-1];
    assign more   = drop1 && w_valid[1] && (w_age[1] >= win);
    assign append = !more;

    always_comb begin
        ctl.step   = accept || (r_drain && out_free);
        ctl.kill   = accept;
        ctl.shift  = drop1 || full;
        ctl.append = append;
        ctl.clear  = append && cur_last;
    end

    always_comb begin
        front = cur_v;
        if (w_svalid[0]) begin
            front = ctl.shift ? w_value[1] : w_value[0];
        end
        n_seen = (r_seen != AW'(WINDOW_MAX)) ? r_seen + 1'b1 : r_seen;
        emit   = n_seen >= win;
    end

    generate
        for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
            logic                  nxt_valid;
            logic [DATA_WIDTH-1:0] nxt_value;
            logic [AW-1:0]         nxt_age;
            logic                  prv_svalid;

            if (g == WINDOW_MAX - 1) begin : g_tail
                assign nxt_valid = 1'b0;
                assign nxt_value = '0;
                assign nxt_age   = '0;
            end else begin : g_body
                assign nxt_valid = w_valid[g+1];
                assign nxt_value = w_value[g+1];
                assign nxt_age   = w_age[g+1];
            end

            if (g == 0) begin : g_head
                assign prv_svalid = 1'b1;
            end else begin : g_rest
                assign prv_svalid = w_svalid[g-1];
            end

            swm_cell #(
                .WINDOW_MAX (WINDOW_MAX),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_sample      (cur_v),
                .i_next_valid  (nxt_valid),
                .i_next_value  (nxt_value),
                .i_next_age    (nxt_age),
                .i_prev_svalid (prv_svalid),
                .o_valid       (w_valid[g]),
                .o_value       (w_value[g]),
                .o_age         (w_age[g]),
                .o_svalid      (w_svalid[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= swm_pkg::WINDOW_RESET;
            r_drain   <= 1'b0;
            r_seen    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            if (ctl.step) begin
                r_drain <= more;
                if (append) begin
                    r_seen <= cur_last ? '0 : n_seen;
                end
            end
            if (out_free) begin
                r_o_valid <= ctl.step && append && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_v    <= i_s_axis_tdata[DATA_WIDTH-1:0];
            r_pend_last <= i_s_axis_tlast;
        end
        if (out_free) begin
            r_o_data <= front;
            r_o_last <= cur_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = TW'(r_o_data);
    assign o_m_axis_tlast  = r_o_last;

endmodule

// File: src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding window maximum, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker #(
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
    localparam int TW = ((DATA_WIDTH + 7) / 8) * 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_axis_tvalid,
    input logic          o_s_axis_tready,
    input logic          o_m_axis_tvalid,
    input logic          i_m_axis_tready,
    input logic [TW-1:0] o_m_axis_tdata,
    input logic          o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("sample taken while result slot is blocked");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready)
            || $past(!o_s_axis_tready))
        else $error("result beat without a sample behind it");

endmodule

bind sliding_window_maximum swm_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_swm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: dv/sliding_window_maximum_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb
// Streams signed samples through the window maximum block and checks each
// result beat against an in-bench deque model or a value typed in the
// directed table, which covers the extremes, short arrays, window sizes
// 0/1/127 and mid-array window changes. Random arrays follow over a series of
// window settings, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = swm_pkg::DATA_WIDTH_DEF;
    localparam int TW = ((DW + 7) / 8) * 8;
    localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
    localparam int CW = swm_pkg::CFG_WIDTH;
    localparam int RAND_SAMPLES = 525;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int DIR_ROWS = 25;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_TYPED,
        CHK_SILENT
    } t_beat_chk;

    typedef struct {
        logic signed [DW-1:0] max_val;
        logic                 last;
    } t_max_result;

    typedef struct {
        bit            do_cfg;
        logic [CW-1:0] cfg;
        logic [DW-1:0] sample;
        logic          last;
        t_beat_chk     chk;
        logic [DW-1:0] typed_max;
    } t_dir_row;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [CW-1:0] cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [TW-1:0] s_tdata = '0;
    logic          s_tlast = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [TW-1:0] m_tdata;
    logic          m_tlast;

    t_beat_chk     beat_chk = CHK_PREDICT;
    logic [DW-1:0] beat_typed = '0;

    // deque model state
    logic signed [DW-1:0] dq_val [WMAX];
    logic [6:0]           dq_age [WMAX];
    int                   dq_len = 0;
    int                   seen = 0;
    logic [CW-1:0]        win_reg = swm_pkg::WINDOW_RESET;

    t_max_result max_expected [$];
    int          mismatches = 0;
    int          hold_reqs = 0;
    int          hold_done = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{0, 7'd0,   32'd5,         1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'h8000_0000, 1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'h7FFF_FFFF, 1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'd3,         1'b0, CHK_TYPED,   32'h7FFF_FFFF},
        '{0, 7'd0,   32'hFFFF_FFFF, 1'b0, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'hFFFF_FFFF, 1'b0, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'd2,         1'b1, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'd9,         1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'd10,        1'b1, CHK_SILENT,  32'd0},
        '{1, 7'd1,   32'h8000_0000, 1'b0, CHK_TYPED,   32'h8000_0000},
        '{0, 7'd0,   32'h7FFF_FFFF, 1'b0, CHK_TYPED,   32'h7FFF_FFFF},
        '{0, 7'd0,   32'd0,         1'b1, CHK_TYPED,   32'd0},
        '{1, 7'd0,   32'd7,         1'b0, CHK_TYPED,   32'd7},
        '{0, 7'd0,   32'hFFFF_FFF9, 1'b1, CHK_TYPED,   32'hFFFF_FFF9},
        '{1, 7'd127, 32'd1,         1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'd2,         1'b1, CHK_SILENT,  32'd0},
        '{1, 7'd3,   32'd9,         1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'd8,         1'b0, CHK_SILENT,  32'd0},
        '{0, 7'd0,   32'd7,         1'b0, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'd6,         1'b0, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'd5,         1'b0, CHK_PREDICT, 32'd0},
        '{1, 7'd2,   32'd4,         1'b0, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'd4,         1'b0, CHK_PREDICT, 32'd0},
        '{1, 7'd6,   32'hAAAA_AAAA, 1'b0, CHK_PREDICT, 32'd0},
        '{0, 7'd0,   32'h5555_5555, 1'b1, CHK_PREDICT, 32'd0}
    };

    sliding_window_maximum i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // sample
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // window_max
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int clamp_window(input int w);
        if (w < 1) return 1;
        if (w > WMAX) return WMAX;
        return w;
    endfunction

    function automatic bit window_max_predict(input logic signed [DW-1:0] smp,
                                              input logic lst,
                                              output logic signed [DW-1:0] wmax);
        int w;
        int drop;
        bit emit;
        w = clamp_window(int'(win_reg));
        for (int i = 0; i < dq_len; i++) begin
            if (dq_age[i] < WMAX) dq_age[i] = dq_age[i] + 7'd1;
        end
        while (dq_len > 0 && dq_val[dq_len-1] < smp) dq_len--;
        drop = 0;
        while (drop < dq_len && dq_age[drop] >= w) drop++;
        if (dq_len >= WMAX && drop == 0) drop = 1;
        for (int i = 0; i + drop < dq_len; i++) begin
            dq_val[i] = dq_val[i+drop];
            dq_age[i] = dq_age[i+drop];
        end
        dq_len -= drop;
        dq_val[dq_len] = smp;
        dq_age[dq_len] = '0;
        dq_len++;
        if (seen < WMAX) seen++;
        emit = (seen >= w);
        wmax = dq_val[0];
        if (lst) begin
            dq_len = 0;
            seen = 0;
        end
        return emit;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DW-1:0] next_sample(input logic [DW-1:0] prev);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2, 3: return $urandom;
            4, 5, 6: return DW'($signed($urandom_range(0, 16)) - 8);
            default: return prev - DW'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic int plan_array_len(input int w);
        if ($urandom_range(0, 99) < 15) return $urandom_range(1, w);
        return w + $urandom_range(0, w + 4);
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // update the model on each write and sample beat, then check result beats
    always @(posedge clk) begin : result_check
        logic signed [DW-1:0] pred;
        bit                   emits;
        t_max_result          want;
        if (rst_n) begin
            if (cfg_we) win_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                emits = window_max_predict(s_tdata[DW-1:0], s_tlast, pred);
                case (beat_chk)
                    CHK_PREDICT: if (emits) max_expected.push_back('{pred, s_tlast});
                    CHK_TYPED: max_expected.push_back('{beat_typed, s_tlast});
                    default: ;
                endcase
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                if (max_expected.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[DW-1:0], '0);
                end else begin
                    want = max_expected.pop_front();
                    if (m_tdata[DW-1:0] !== want.max_val)
                        report_mismatch("window_max", m_tdata[DW-1:0], want.max_val);
                    if (m_tlast !== want.last)
                        report_mismatch("last_out", DW'(m_tlast), DW'(want.last));
                end
            end
        end
    end

    initial begin : sink_ready
        int run;
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_reqs != hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 30);
            for (int k = 0; k < run; k++) begin
                @(posedge clk);
                if (hold_reqs != hold_done) break;
            end
            stall = (hold_reqs != hold_done) ? 0 : pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_sample(input logic [DW-1:0] smp, input logic lst,
                               input t_beat_chk chk, input logic [DW-1:0] typed_max);
        int gap;
        gap = (hold_reqs != hold_done) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= TW'(smp);
        s_tlast <= lst;
        beat_chk <= chk;
        beat_typed <= typed_max;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (max_expected.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CW-1:0] value);
        drain_results();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int            sent;
        int            phase;
        int            cur_win;
        int            plen;
        int            arr_pos;
        int            arr_len;
        logic [CW-1:0] wval;
        logic [DW-1:0] smp;
        logic [DW-1:0] prev;
        logic          lst;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].do_cfg) write_window(dir_rows[i].cfg);
            send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].chk,
                        dir_rows[i].typed_max);
        end

        sent = 0;
        phase = 0;
        arr_pos = 0;
        arr_len = 1;
        prev = '0;
        while (sent < RAND_SAMPLES) begin
            case (phase)
                0: wval = 7'd64;
                1: wval = 7'd1;
                default: begin
                    case ($urandom_range(0, 11))
                        0: wval = 7'd64;
                        1: wval = 7'd1;
                        2: wval = $urandom_range(0, 1) ? 7'd0 : 7'd127;
                        3, 4: wval = CW'($urandom_range(1, 64));
                        default: wval = CW'($urandom_range(2, 8));
                    endcase
                end
            endcase
            write_window(wval);
            cur_win = clamp_window(int'(wval));
            // stall the output for a long stretch while samples keep coming
            if (phase == 2) hold_reqs++;
            plen = (cur_win >= 32) ? $urandom_range(100, 160) : $urandom_range(20, 60);
            if (plen > RAND_SAMPLES - sent) plen = RAND_SAMPLES - sent;
            repeat (plen) begin
                if (arr_pos == 0) arr_len = plan_array_len(cur_win);
                smp = next_sample(prev);
                lst = (arr_pos >= arr_len - 1);
                send_sample(smp, lst, CHK_PREDICT, '0);
                prev = smp;
                sent++;
                arr_pos = lst ? 0 : arr_pos + 1;
            end
            phase++;
        end

        drain_results();
        if (mismatches == 0 && max_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
